### rtl/hslrgb_pkg.sv
package hslrgb_pkg;

    // Q0.24 constants, only the fraction bits are needed for values below one; ONE_Q24 is signed Q2.24
    localparam logic [23:0] HALF_Q24   = 24'h800000;
    localparam logic [23:0] SIXTH_Q24  = 24'h2AAAAB;
    localparam logic [23:0] THIRD_Q24  = 24'h555555;
    localparam logic [23:0] TWO3RD_Q24 = 24'hAAAAAB;
    localparam logic signed [25:0] ONE_Q24 = 26'sh1000000;

    // 0x3FC00000 / 2^22: the channel scale folded into one narrow multiply
    localparam logic [7:0] CHAN_SCALE = 8'd255;

    // number of register stages from input to output register
    localparam int unsigned NUM_STAGES = 6;

    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } hslrgb_seg_t;

    // per-stage load enables handed to the channel datapath
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } hslrgb_ld_t;

endpackage

### rtl/hslrgb_in_if.sv
interface hslrgb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink (input valid, input hue, input saturation, input lightness,
                  output ready);
endinterface

### rtl/hslrgb_out_if.sv
interface hslrgb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_565;

    modport source (output valid, output pixel_565, input ready);
    modport sink (input valid, input pixel_565, output ready);
endinterface

### rtl/hslrgb_chan.sv
module hslrgb_chan (
    input  logic                clk,
    input  hslrgb_pkg::hslrgb_ld_t ld,
    input  logic signed [25:0]  t_raw,
    input  logic [24:0]         d,
    input  logic signed [26:0]  p,
    input  logic [24:0]         q,
    output logic [7:0]          c8
);

    logic signed [25:0]       t_w;
    hslrgb_pkg::hslrgb_seg_t  seg_next;
    logic [23:0]              m_next;

    hslrgb_pkg::hslrgb_seg_t  seg1_reg;
    logic [23:0]              m1_reg;
    hslrgb_pkg::hslrgb_seg_t  seg2_reg;
    logic [23:0]              m2_reg;
    hslrgb_pkg::hslrgb_seg_t  seg3_reg;
    logic [48:0]              prod_next;
    logic [24:0]              x3_reg;
    logic [27:0]              x6;
    logic signed [29:0]       c_next;
    logic signed [29:0]       c4_reg;
    logic [36:0]              scaled;
    logic [12:0]              w;
    logic [7:0]               c8_next;
    logic [7:0]               c8_reg;

    // hue wrap and segment select
    always_comb
    begin
        t_w = t_raw;
        if (t_raw < 26'sd0)
        begin
            t_w = t_raw + hslrgb_pkg::ONE_Q24;
        end
        else if (t_raw > hslrgb_pkg::ONE_Q24)
        begin
            t_w = t_raw - hslrgb_pkg::ONE_Q24;
        end

        m_next = t_w[23:0];
        if (t_w < $signed({2'b00, hslrgb_pkg::SIXTH_Q24}))
        begin
            seg_next = hslrgb_pkg::SEG_RISE;
        end
        else if (t_w < $signed({2'b00, hslrgb_pkg::HALF_Q24}))
        begin
            seg_next = hslrgb_pkg::SEG_HIGH;
        end
        else if (t_w < $signed({2'b00, hslrgb_pkg::TWO3RD_Q24}))
        begin
            seg_next = hslrgb_pkg::SEG_FALL;
            m_next   = hslrgb_pkg::TWO3RD_Q24 - t_w[23:0];
        end
        else
        begin
            seg_next = hslrgb_pkg::SEG_LOW;
        end
    end

    assign prod_next = {24'd0, d} * {25'd0, m2_reg};

    // ramp value, the 6x is exact so it is shift and add
    always_comb
    begin
        x6 = ({3'b000, x3_reg} << 1) + ({3'b000, x3_reg} << 2);
        case (seg3_reg)
            hslrgb_pkg::SEG_RISE,
            hslrgb_pkg::SEG_FALL: c_next = {{3{p[26]}}, p} + $signed({2'b00, x6});
            hslrgb_pkg::SEG_HIGH: c_next = $signed({5'd0, q});
            hslrgb_pkg::SEG_LOW:  c_next = {{3{p[26]}}, p};
            default:              c_next = {{3{p[26]}}, p};
        endcase
    end

    // 255 * c / 2^24 with clamp to 0..255
    always_comb
    begin
        scaled = {8'd0, c4_reg[28:0]} * {29'd0, hslrgb_pkg::CHAN_SCALE};
        w      = scaled[36:24];
        if (c4_reg <= 30'sd0)
        begin
            c8_next = 8'd0;
        end
        else if (w > 13'd255)
        begin
            c8_next = 8'd255;
        end
        else
        begin
            c8_next = w[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.s1)
        begin
            seg1_reg <= seg_next;
            m1_reg   <= m_next;
        end
        if (ld.s2)
        begin
            seg2_reg <= seg1_reg;
            m2_reg   <= m1_reg;
        end
        if (ld.s3)
        begin
            seg3_reg <= seg2_reg;
            x3_reg   <= prod_next[48:24];
        end
        if (ld.s4)
        begin
            c4_reg <= c_next;
        end
        if (ld.s5)
        begin
            c8_reg <= c8_next;
        end
    end

    assign c8 = c8_reg;

endmodule

### rtl/hsl_to_rgb565_fixed.sv
// HSL to RGB565 converter. Takes one hue/saturation/lightness transaction per clock
// unless the output stalls and returns one 16-bit pixel (red 15..11, green 10..5,
// blue 4..0). The datapath is a six-stage pipeline: input scaling and hue segment
// select, q/p, the per-channel ramp multiply, the ramp add, the 255 scale with clamp,
// and the output register. Each stage holds a valid bit and loads whenever it is
// empty or the stage after it moves, so empty slots are filled and a stalled output
// only holds back as far as the pipeline is full. Zero saturation gives a gray pixel.
module hsl_to_rgb565_fixed (
    input  logic          clk,
    input  logic          rst_n,
    hslrgb_in_if.sink     hsl,
    hslrgb_out_if.source  rgb
);

    localparam int unsigned NS = hslrgb_pkg::NUM_STAGES;

    logic [NS:1] v_reg;
    logic [NS:1] rdy;
    hslrgb_pkg::hslrgb_ld_t ld;

    logic [23:0] hq;
    logic [23:0] sq;
    logic [23:0] lq;
    logic signed [25:0] t_red;
    logic signed [25:0] t_grn;
    logic signed [25:0] t_blu;

    logic [47:0] prod_next;
    logic [47:0] prod1_reg;
    logic [23:0] lq1_reg;
    logic [23:0] sq1_reg;

    logic [24:0] q_next;
    logic signed [26:0] p_next;
    logic [24:0] d_next;
    logic [24:0] q2_reg;
    logic signed [26:0] p2_reg;
    logic [24:0] d2_reg;
    logic [24:0] q3_reg;
    logic signed [26:0] p3_reg;

    logic [NS-1:1] gray_reg;
    logic [7:0]    lgt_reg [1:NS-1];

    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;
    logic [15:0] pixel_next;
    logic [15:0] pixel_reg;

    // a stage can load when it is empty or its contents move on
    always_comb
    begin
        rdy[NS] = !v_reg[NS] || rgb.ready;
        for (int k = NS - 1; k >= 1; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign ld = '{s1: rdy[1], s2: rdy[2], s3: rdy[3], s4: rdy[4], s5: rdy[5]};

    assign hsl.ready = rdy[1];
    assign rgb.valid = v_reg[NS];
    assign rgb.pixel_565 = pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[1])
            begin
                v_reg[1] <= hsl.valid;
            end
            for (int k = 2; k <= NS; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // x * 0x10101 is the byte repeated three times
    assign hq = {hsl.hue, hsl.hue, hsl.hue};
    assign sq = {hsl.saturation, hsl.saturation, hsl.saturation};
    assign lq = {hsl.lightness, hsl.lightness, hsl.lightness};

    assign t_red = $signed({2'b00, hq}) + $signed({2'b00, hslrgb_pkg::THIRD_Q24});
    assign t_grn = $signed({2'b00, hq});
    assign t_blu = $signed({2'b00, hq}) - $signed({2'b00, hslrgb_pkg::THIRD_Q24});

    assign prod_next = lq * sq;

    // q, p and q - p, all exact since the products are nonnegative
    always_comb
    begin
        if (lq1_reg < hslrgb_pkg::HALF_Q24)
        begin
            q_next = {1'b0, lq1_reg} + {1'b0, prod1_reg[47:24]};
        end
        else
        begin
            q_next = 25'({2'b00, lq1_reg} + {2'b00, sq1_reg} - {2'b00, prod1_reg[47:24]});
        end
        p_next = $signed({2'b00, lq1_reg, 1'b0}) - $signed({2'b00, q_next});
        d_next = 25'($signed({2'b00, q_next}) - p_next);
    end

    always_ff @(posedge clk)
    begin
        if (ld.s1)
        begin
            prod1_reg   <= prod_next;
            lq1_reg     <= lq;
            sq1_reg     <= sq;
            gray_reg[1] <= (hsl.saturation == 8'd0);
            lgt_reg[1]  <= hsl.lightness;
        end
        if (ld.s2)
        begin
            q2_reg <= q_next;
            p2_reg <= p_next;
            d2_reg <= d_next;
        end
        if (ld.s3)
        begin
            q3_reg <= q2_reg;
            p3_reg <= p2_reg;
        end
        for (int k = 2; k <= NS - 1; k++)
        begin
            if (rdy[k])
            begin
                gray_reg[k] <= gray_reg[k-1];
                lgt_reg[k]  <= lgt_reg[k-1];
            end
        end
        if (rdy[NS])
        begin
            pixel_reg <= pixel_next;
        end
    end

    hslrgb_chan u_red (
        .clk   (clk),
        .ld    (ld),
        .t_raw (t_red),
        .d     (d2_reg),
        .p     (p3_reg),
        .q     (q3_reg),
        .c8    (r8)
    );

    hslrgb_chan u_grn (
        .clk   (clk),
        .ld    (ld),
        .t_raw (t_grn),
        .d     (d2_reg),
        .p     (p3_reg),
        .q     (q3_reg),
        .c8    (g8)
    );

    hslrgb_chan u_blu (
        .clk   (clk),
        .ld    (ld),
        .t_raw (t_blu),
        .d     (d2_reg),
        .p     (p3_reg),
        .q     (q3_reg),
        .c8    (b8)
    );

    // pack 5-6-5, gray takes the lightness for all channels
    always_comb
    begin
        if (gray_reg[NS-1])
        begin
            pixel_next = {lgt_reg[NS-1][7:3], lgt_reg[NS-1][7:2], lgt_reg[NS-1][7:3]};
        end
        else
        begin
            pixel_next = {r8[7:3], g8[7:2], b8[7:3]};
        end
    end

endmodule
